### hw/rtl/tslf_pkg.sv
// Shared types, constants and the byte rendering function of the text line formatter.
`default_nettype none

package tslf_pkg;

    localparam int NUMBER_WIDTH_DEF   = 6;
    localparam int COUNTER_DIGITS_DEF = 7;
    localparam int FIFO_DEPTH         = 4;
    localparam int MAX_RESULTS        = 12;
    localparam int RES_CNT_W          = $clog2(MAX_RESULTS);
    localparam int CFG_INDEX_W        = 3;
    localparam int CFG_DATA_W         = 8;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_NUMBER_MODE      = 3'd0,
        REG_SQUEEZE_BLANK    = 3'd1,
        REG_SHOW_ENDS        = 3'd2,
        REG_SHOW_TABS        = 3'd3,
        REG_SHOW_NONPRINTING = 3'd4
    } t_reg_idx;

    localparam logic [1:0] NUM_OFF = 2'd0;
    localparam logic [1:0] NUM_ALL = 2'd1;

    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_QMARK  = 8'h3F;
    localparam logic [7:0] CH_I      = 8'h49;
    localparam logic [7:0] CH_M      = 8'h4D;
    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_DEL    = 8'h7F;
    localparam logic [7:0] CTRL_OFFSET = 8'h40;
    localparam logic [7:0] CTRL_LIMIT  = 8'h20;

    typedef struct packed {
        logic [1:0] number_mode;
        logic       squeeze_blank;
        logic       show_ends;
        logic       show_tabs;
        logic       show_nonprinting;
    } t_cfg;

    typedef enum logic [1:0] {
        PH_PAD,
        PH_DIG,
        PH_TAB,
        PH_REND
    } t_phase;

    // Displayed form of one byte without the line number: bytes[0] goes out first.
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [2:0]      len;
    } t_render;

    function automatic t_render render_byte(input logic [7:0] b, input t_cfg cfg);
        t_render    r;
        logic [7:0] c;
        r = '0;
        c = {1'b0, b[6:0]};
        if (cfg.show_nonprinting && b[7]) begin
            r.bytes[0] = CH_M;
            r.bytes[1] = CH_DASH;
            if (c < CTRL_LIMIT) begin
                r.bytes[2] = CH_CARET;
                r.bytes[3] = c + CTRL_OFFSET;
                r.len      = 3'd4;
            end else if (c == CH_DEL) begin
                r.bytes[2] = CH_CARET;
                r.bytes[3] = CH_QMARK;
                r.len      = 3'd4;
            end else begin
                r.bytes[2] = c;
                r.len      = 3'd3;
            end
        end else if (cfg.show_nonprinting &&
                     ((b < CTRL_LIMIT && b != CH_TAB && b != CH_NL) || b == CH_DEL)) begin
            r.bytes[0] = CH_CARET;
            r.bytes[1] = (b == CH_DEL) ? CH_QMARK : b + CTRL_OFFSET;
            r.len      = 3'd2;
        end else if (b == CH_NL && cfg.show_ends) begin
            r.bytes[0] = CH_DOLLAR;
            r.bytes[1] = CH_NL;
            r.len      = 3'd2;
        end else if (b == CH_TAB && cfg.show_tabs) begin
            r.bytes[0] = CH_CARET;
            r.bytes[1] = CH_I;
            r.len      = 3'd2;
        end else begin
            r.bytes[0] = b;
            r.len      = 3'd1;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/tslf_fifo.sv
// Small command queue between the classifying front end and the output sequencer.
`default_nettype none

module tslf_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic [WIDTH-1:0]      o_data,
    output logic                  o_empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wptr, r_rptr;
    logic [CNT_W-1:0] r_count;

    function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= next_ptr(r_wptr);
            end
            if (i_pop) begin
                r_rptr <= next_ptr(r_rptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/tslf_front.sv
// Front end: accepts input words, tracks line and squeeze state, bumps the BCD line counter.
`default_nettype none

module tslf_front
    import tslf_pkg::*;
#(
    parameter int COUNTER_DIGITS = COUNTER_DIGITS_DEF,
    localparam int ENTRY_W = 1 + 4 * COUNTER_DIGITS + $bits(t_render)
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_cfg               i_cfg,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic [7:0]         i_data_byte,
    input  wire logic               i_file_start,
    input  wire logic               i_full,
    output logic                    o_push,
    output logic [ENTRY_W-1:0]      o_entry
);

    logic                            r_prev_nl, r_started, r_squeezing;
    logic [COUNTER_DIGITS-1:0][3:0]  r_count;

    logic                            accept, is_nl, line_start, sq_held;
    logic                            emit, n_squeezing, do_num, all_nine, carry;
    logic [COUNTER_DIGITS-1:0][3:0]  bumped, n_count;

    assign o_ready = !i_full;
    assign accept  = i_valid && !i_full;

    always_comb begin
        is_nl      = (i_data_byte == CH_NL);
        line_start = r_prev_nl || !r_started;
        sq_held    = (i_file_start || !i_cfg.squeeze_blank) ? 1'b0 : r_squeezing;

        emit        = 1'b1;
        n_squeezing = sq_held;
        if (i_cfg.squeeze_blank) begin
            if (is_nl && line_start) begin
                emit        = !sq_held;
                n_squeezing = 1'b1;
            end else begin
                n_squeezing = 1'b0;
            end
        end

        // Mode 3 behaves like nonblank-only numbering.
        do_num = emit && (i_cfg.number_mode != NUM_OFF) && line_start &&
                 ((i_cfg.number_mode == NUM_ALL) || !is_nl);

        // Decimal increment that sticks at all nines.
        all_nine = 1'b1;
        for (int i = 0; i < COUNTER_DIGITS; i++) begin
            if (r_count[i] != 4'd9) begin
                all_nine = 1'b0;
            end
        end
        bumped = r_count;
        carry  = !all_nine;
        for (int i = 0; i < COUNTER_DIGITS; i++) begin
            if (carry) begin
                if (r_count[i] == 4'd9) begin
                    bumped[i] = 4'd0;
                end else begin
                    bumped[i] = r_count[i] + 4'd1;
                    carry     = 1'b0;
                end
            end
        end
        n_count = do_num ? bumped : r_count;

        o_push  = accept && emit;
        o_entry = {do_num, n_count, render_byte(i_data_byte, i_cfg)};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_nl   <= 1'b0;
            r_started   <= 1'b0;
            r_squeezing <= 1'b0;
            r_count     <= '0;
        end else if (accept) begin
            r_prev_nl   <= is_nl;
            r_started   <= 1'b1;
            r_squeezing <= n_squeezing;
            r_count     <= n_count;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/tslf_back.sv
// Back end: expands one queued command into padding, digits and tab when numbered, then rendered bytes.
`default_nettype none

module tslf_back
    import tslf_pkg::*;
#(
    parameter int NUMBER_WIDTH   = NUMBER_WIDTH_DEF,
    parameter int COUNTER_DIGITS = COUNTER_DIGITS_DEF,
    localparam int ENTRY_W = 1 + 4 * COUNTER_DIGITS + $bits(t_render)
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_empty,
    input  wire logic [ENTRY_W-1:0] i_entry,
    output logic                    o_pop,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic [7:0]              o_byte,
    output logic                    o_last
);

    localparam int SIG_W  = $clog2(COUNTER_DIGITS + 1);
    localparam int PAD_W  = $clog2(NUMBER_WIDTH + 1);
    localparam int DIDX_W = $clog2(COUNTER_DIGITS);
    localparam int CMP_W  = ((SIG_W > PAD_W) ? SIG_W : PAD_W) + 1;

    logic                            ent_do_num;
    logic [COUNTER_DIGITS-1:0][3:0]  ent_digits;
    t_render                         ent_rend;
    logic [SIG_W-1:0]                sig;
    logic [CMP_W-1:0]                pad_wide;
    logic [PAD_W-1:0]                ent_pad;
    t_phase                          ent_phase;

    logic                            r_busy, r_ov, r_ol;
    logic [7:0]                      r_ob;
    t_phase                          r_phase, n_phase;
    logic [COUNTER_DIGITS-1:0][3:0]  r_digits;
    t_render                         r_rend;
    logic [PAD_W-1:0]                r_pad, n_pad;
    logic [DIDX_W-1:0]               r_didx, n_didx;
    logic [1:0]                      r_ridx, n_ridx;
    logic [RES_CNT_W-1:0]            r_cnt;

    logic                            step, seq_end, fin;
    logic [7:0]                      cur_byte;

    assign ent_do_num = i_entry[ENTRY_W-1];
    assign ent_digits = i_entry[ENTRY_W-2 -: 4 * COUNTER_DIGITS];
    assign ent_rend   = i_entry[$bits(t_render)-1:0];

    // Count of significant digits; a zero counter still prints one digit.
    always_comb begin
        sig = SIG_W'(1);
        for (int i = 1; i < COUNTER_DIGITS; i++) begin
            if (ent_digits[i] != 4'd0) begin
                sig = SIG_W'(i + 1);
            end
        end
        pad_wide = (CMP_W'(NUMBER_WIDTH) > CMP_W'(sig)) ?
                   CMP_W'(NUMBER_WIDTH) - CMP_W'(sig) : '0;
        ent_pad  = pad_wide[PAD_W-1:0];
        if (!ent_do_num) begin
            ent_phase = PH_REND;
        end else if (ent_pad != '0) begin
            ent_phase = PH_PAD;
        end else begin
            ent_phase = PH_DIG;
        end
    end

    assign o_pop = !r_busy && !i_empty;
    assign step  = r_busy && (!r_ov || i_ready);

    always_comb begin
        n_phase  = r_phase;
        n_pad    = r_pad;
        n_didx   = r_didx;
        n_ridx   = r_ridx;
        cur_byte = CH_SPACE;
        seq_end  = 1'b0;
        case (r_phase)
            PH_PAD: begin
                cur_byte = CH_SPACE;
                n_pad    = r_pad - PAD_W'(1);
                if (r_pad == PAD_W'(1)) begin
                    n_phase = PH_DIG;
                end
            end
            PH_DIG: begin
                cur_byte = CH_ZERO + {4'd0, r_digits[r_didx]};
                if (r_didx == '0) begin
                    n_phase = PH_TAB;
                end else begin
                    n_didx = r_didx - DIDX_W'(1);
                end
            end
            PH_TAB: begin
                cur_byte = CH_TAB;
                n_phase  = PH_REND;
            end
            PH_REND: begin
                cur_byte = r_rend.bytes[r_ridx];
                n_ridx   = r_ridx + 2'd1;
                seq_end  = ({1'b0, r_ridx} == r_rend.len - 3'd1);
            end
            default: begin
                n_phase = PH_REND;
            end
        endcase
        // Words past the per-item limit are dropped.
        fin = seq_end || (r_cnt == RES_CNT_W'(MAX_RESULTS - 1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_ov    <= 1'b0;
            r_phase <= PH_REND;
        end else begin
            if (o_pop) begin
                r_busy  <= 1'b1;
                r_phase <= ent_phase;
            end else if (step) begin
                r_busy  <= !fin;
                r_phase <= n_phase;
            end
            if (step) begin
                r_ov <= 1'b1;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_digits <= ent_digits;
            r_rend   <= ent_rend;
            r_pad    <= ent_pad;
            r_didx   <= DIDX_W'(sig - SIG_W'(1));
            r_ridx   <= 2'd0;
            r_cnt    <= '0;
        end else if (step) begin
            r_pad  <= n_pad;
            r_didx <= n_didx;
            r_ridx <= n_ridx;
            r_cnt  <= r_cnt + RES_CNT_W'(1);
        end
        if (step) begin
            r_ob <= cur_byte;
            r_ol <= fin;
        end
    end

    assign o_valid = r_ov;
    assign o_byte  = r_ob;
    assign o_last  = r_ol;

endmodule

`default_nettype wire

### hw/rtl/text_stream_line_formatter_top.sv
// A word taken on the slave side is queued, loaded into the sequencer from the queue and
// then registered into the output word before it shows on the master side. The output
// runs at one word per cycle while the sink takes them; the sequencer loads a command
// only when idle, so it takes no new command until the last one is fully expanded.
// Reset is synchronous and active low; it clears the queue, the line state, the line
// counter and all configuration registers.
`default_nettype none

module text_stream_line_formatter_top
    import tslf_pkg::*;
#(
    parameter int NUMBER_WIDTH   = NUMBER_WIDTH_DEF,
    parameter int COUNTER_DIGITS = COUNTER_DIGITS_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire logic [7:0]             s_axis_tdata,   // [7:0] data_byte
    input  wire logic                   s_axis_tuser,   // [0] file_start
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic [7:0]                  m_axis_tdata,   // [7:0] out_byte
    output logic                        m_axis_tlast,
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int ENTRY_W = 1 + 4 * COUNTER_DIGITS + $bits(t_render);

    t_cfg               r_cfg;
    logic               push, pop, full, empty;
    logic [ENTRY_W-1:0] push_entry, head_entry;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_NUMBER_MODE:      r_cfg.number_mode      <= i_cfg_data[1:0];
                REG_SQUEEZE_BLANK:    r_cfg.squeeze_blank    <= i_cfg_data[0];
                REG_SHOW_ENDS:        r_cfg.show_ends        <= i_cfg_data[0];
                REG_SHOW_TABS:        r_cfg.show_tabs        <= i_cfg_data[0];
                REG_SHOW_NONPRINTING: r_cfg.show_nonprinting <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    tslf_front #(
        .COUNTER_DIGITS(COUNTER_DIGITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_data_byte  (s_axis_tdata),
        .i_file_start (s_axis_tuser),
        .i_full       (full),
        .o_push       (push),
        .o_entry      (push_entry)
    );

    tslf_fifo #(
        .WIDTH(ENTRY_W),
        .DEPTH(FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_entry),
        .o_full  (full),
        .i_pop   (pop),
        .o_data  (head_entry),
        .o_empty (empty)
    );

    tslf_back #(
        .NUMBER_WIDTH  (NUMBER_WIDTH),
        .COUNTER_DIGITS(COUNTER_DIGITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_entry (head_entry),
        .o_pop   (pop),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_byte  (m_axis_tdata),
        .o_last  (m_axis_tlast)
    );

endmodule

`default_nettype wire

### hw/rtl/tslf_checker.sv
// Port-level checks of the text line formatter, bound to the top level.
`default_nettype none

module tslf_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       s_axis_tready,
    input wire logic       m_axis_tvalid,
    input wire logic       m_axis_tready,
    input wire logic [7:0] m_axis_tdata,
    input wire logic       m_axis_tlast
);

    // Reset empties the output register and the queue.
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && s_axis_tready)
        else $error("output not idle or input not ready after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled output word changed");

    // The words of one item leave without gaps once the sink takes them.
    a_run_unbroken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid)
        else $error("gap inside the output of one item");

endmodule

bind text_stream_line_formatter_top tslf_checker u_tslf_checker (.*);

`default_nettype wire
